// ===== hw/rtl/snfcs_pkg.sv =====
// Shared types, codes and word builders for the SPI NOR flash command sequencer.
`default_nettype none

package snfcs_pkg;

    localparam int unsigned MaxWords = 3;

    typedef enum logic [2:0] {
        CMD_READ_ID      = 3'd0,
        CMD_ERASE_SECTOR = 3'd1,
        CMD_PAGE_WRITE   = 3'd2,
        CMD_READ         = 3'd3,
        CMD_APPEND       = 3'd4,
        CMD_WRITE_DATA   = 3'd5,
        CMD_SPI_RECEIVED = 3'd6
    } t_command;

    typedef enum logic [2:0] {
        ACT_SEND_BYTE    = 3'd0,
        ACT_RAISE_SELECT = 3'd1,
        ACT_READ_DATA    = 3'd2,
        ACT_ID_RESULT    = 3'd3,
        ACT_DONE         = 3'd4,
        ACT_WANT_DATA    = 3'd5
    } t_action;

    typedef enum logic [0:0] {
        CFG_RECORD_LENGTH   = 1'b0,
        CFG_PAGE_FILL_LIMIT = 1'b1
    } t_cfg_index;

    localparam logic [7:0] OPC_READ_ID    = 8'h9F;
    localparam logic [7:0] OPC_WREN       = 8'h06;
    localparam logic [7:0] OPC_WRDI       = 8'h04;
    localparam logic [7:0] OPC_READ_SR    = 8'h05;
    localparam logic [7:0] OPC_ERASE      = 8'h20;
    localparam logic [7:0] OPC_PROGRAM    = 8'h02;
    localparam logic [7:0] OPC_READ       = 8'h03;
    localparam logic [7:0] DUMMY_BYTE     = 8'hFF;

    localparam logic [8:0] RecordLengthReset  = 9'd50;
    localparam logic [8:0] PageFillLimitReset = 9'd250;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  block;
        logic [3:0]  sector;
        logic [3:0]  page;
        logic [7:0]  offset;
        logic [15:0] length;
        logic [7:0]  byte_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tx_byte;
        logic [7:0]  read_byte;
        logic [7:0]  manufacturer;
        logic [15:0] device;
        logic        last;
    } t_out_word;

    typedef struct packed {
        t_out_word [MaxWords-1:0] words;
        logic [1:0]               count;
    } t_batch;

    function automatic t_out_word mk_word(input t_action act, input logic [7:0] tx,
                                          input logic [7:0] rd, input logic [7:0] mfr,
                                          input logic [15:0] dev);
        t_out_word w;
        w.action       = act;
        w.tx_byte      = tx;
        w.read_byte    = rd;
        w.manufacturer = mfr;
        w.device       = dev;
        w.last         = 1'b0;
        return w;
    endfunction

    function automatic t_out_word mk_send(input logic [7:0] tx);
        return mk_word(ACT_SEND_BYTE, tx, 8'h00, 8'h00, 16'h0000);
    endfunction

    function automatic t_out_word mk_plain(input t_action act);
        return mk_word(act, 8'h00, 8'h00, 8'h00, 16'h0000);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/snfcs_core.sv =====
// Sequencer state, configuration registers and per-word decision logic.
`default_nettype none

module snfcs_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_go,
    input  wire snfcs_pkg::t_in_word  i_word,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_index,
    input  wire logic [8:0]           i_cfg_data,
    output snfcs_pkg::t_batch         o_batch
);
    import snfcs_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ID_CMD   = 5'd1,
        PH_ID_MFR   = 5'd2,
        PH_ID_D1    = 5'd3,
        PH_ID_D2    = 5'd4,
        PH_POLL_CMD = 5'd5,
        PH_POLL_ST  = 5'd6,
        PH_WREN     = 5'd7,
        PH_OPC      = 5'd8,
        PH_ADR2     = 5'd9,
        PH_ADR1     = 5'd10,
        PH_ADR0     = 5'd11,
        PH_WANT     = 5'd12,
        PH_DATA     = 5'd13,
        PH_RD       = 5'd14,
        PH_WRDI     = 5'd15
    } t_phase;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ERASE = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    t_phase      r_phase, n_phase;
    t_op         r_op, n_op;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [23:0] r_addr, n_addr;
    logic [23:0] r_wptr, n_wptr;
    logic [7:0]  r_id_first, n_id_first;
    logic [7:0]  r_id_high, n_id_high;
    logic [8:0]  r_rec_len;
    logic [8:0]  r_fill_lim;

    t_out_word   w0, w1, w2;
    logic [1:0]  cnt;
    logic [23:0] in_addr;
    logic [23:0] dest;
    logic [15:0] ab;
    logic [7:0]  rx;

    assign in_addr = {i_word.block, i_word.sector, i_word.page, i_word.offset};
    assign rx      = i_word.byte_value;

    always_comb begin
        n_phase      = r_phase;
        n_op         = r_op;
        n_bytes_left = r_bytes_left;
        n_addr       = r_addr;
        n_wptr       = r_wptr;
        n_id_first   = r_id_first;
        n_id_high    = r_id_high;
        w0           = mk_plain(ACT_SEND_BYTE);
        w1           = mk_plain(ACT_SEND_BYTE);
        w2           = mk_plain(ACT_SEND_BYTE);
        cnt          = 2'd0;
        dest         = r_wptr;
        ab           = r_bytes_left;

        if ({1'b0, r_wptr[7:0]} >= r_fill_lim) begin
            dest = {r_wptr[23:8] + 16'd1, 8'h00};
        end

        case (i_word.command)
            CMD_READ_ID, CMD_ERASE_SECTOR, CMD_PAGE_WRITE, CMD_READ, CMD_APPEND: begin
                if (r_phase == PH_IDLE) begin
                    cnt     = 2'd1;
                    n_phase = PH_POLL_CMD;
                    w0      = mk_send(OPC_READ_SR);
                    unique case (i_word.command)
                        CMD_READ_ID: begin
                            w0      = mk_send(OPC_READ_ID);
                            n_phase = PH_ID_CMD;
                        end
                        CMD_ERASE_SECTOR: begin
                            n_op         = OP_ERASE;
                            n_addr       = {in_addr[23:12], 12'h000};
                            n_bytes_left = 16'd0;
                        end
                        CMD_PAGE_WRITE: begin
                            n_op         = OP_WRITE;
                            n_addr       = in_addr;
                            n_bytes_left = i_word.length;
                        end
                        CMD_READ: begin
                            n_op         = OP_READ;
                            n_addr       = in_addr;
                            n_bytes_left = i_word.length;
                        end
                        default: begin
                            n_op         = OP_WRITE;
                            n_addr       = dest;
                            n_bytes_left = {7'd0, r_rec_len};
                            n_wptr       = dest + {15'd0, r_rec_len};
                        end
                    endcase
                end
            end
            CMD_WRITE_DATA: begin
                if (r_phase == PH_WANT) begin
                    cnt     = 2'd1;
                    w0      = mk_send(rx);
                    n_phase = PH_DATA;
                end
            end
            CMD_SPI_RECEIVED: begin
                unique case (r_phase)
                    PH_ID_CMD: begin
                        cnt = 2'd1; w0 = mk_send(OPC_READ_ID); n_phase = PH_ID_MFR;
                    end
                    PH_ID_MFR: begin
                        n_id_first = rx;
                        cnt = 2'd1; w0 = mk_send(DUMMY_BYTE); n_phase = PH_ID_D1;
                    end
                    PH_ID_D1: begin
                        n_id_high = rx;
                        cnt = 2'd1; w0 = mk_send(DUMMY_BYTE); n_phase = PH_ID_D2;
                    end
                    PH_ID_D2: begin
                        cnt     = 2'd3;
                        w0      = mk_plain(ACT_RAISE_SELECT);
                        w1      = mk_word(ACT_ID_RESULT, 8'h00, 8'h00, r_id_first,
                                          {r_id_high, rx});
                        w2      = mk_plain(ACT_DONE);
                        n_phase = PH_IDLE;
                    end
                    PH_POLL_CMD: begin
                        cnt = 2'd1; w0 = mk_send(DUMMY_BYTE); n_phase = PH_POLL_ST;
                    end
                    PH_POLL_ST: begin
                        if (rx[0]) begin
                            cnt = 2'd1; w0 = mk_send(DUMMY_BYTE);
                        end else begin
                            cnt = 2'd2;
                            w0  = mk_plain(ACT_RAISE_SELECT);
                            if (r_op == OP_READ) begin
                                w1 = mk_send(OPC_READ); n_phase = PH_OPC;
                            end else begin
                                w1 = mk_send(OPC_WREN); n_phase = PH_WREN;
                            end
                        end
                    end
                    PH_WREN: begin
                        cnt     = 2'd2;
                        w0      = mk_plain(ACT_RAISE_SELECT);
                        w1      = mk_send((r_op == OP_ERASE) ? OPC_ERASE : OPC_PROGRAM);
                        n_phase = PH_OPC;
                    end
                    PH_OPC: begin
                        cnt = 2'd1; w0 = mk_send(r_addr[23:16]); n_phase = PH_ADR2;
                    end
                    PH_ADR2: begin
                        cnt = 2'd1; w0 = mk_send(r_addr[15:8]); n_phase = PH_ADR1;
                    end
                    PH_ADR1: begin
                        cnt = 2'd1; w0 = mk_send(r_addr[7:0]); n_phase = PH_ADR0;
                    end
                    PH_ADR0, PH_DATA: begin
                        if (r_phase == PH_DATA) begin
                            ab           = r_bytes_left - 16'd1;
                            n_bytes_left = ab;
                        end
                        if (r_op == OP_ERASE || (r_op == OP_WRITE && ab == 16'd0)) begin
                            cnt     = 2'd2;
                            w0      = mk_plain(ACT_RAISE_SELECT);
                            w1      = mk_send(OPC_WRDI);
                            n_phase = PH_WRDI;
                        end else if (r_op == OP_WRITE) begin
                            cnt     = 2'd1;
                            w0      = mk_plain(ACT_WANT_DATA);
                            n_phase = PH_WANT;
                        end else if (ab != 16'd0) begin
                            cnt     = 2'd1;
                            w0      = mk_send(DUMMY_BYTE);
                            n_phase = PH_RD;
                        end else begin
                            cnt     = 2'd2;
                            w0      = mk_plain(ACT_RAISE_SELECT);
                            w1      = mk_plain(ACT_DONE);
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_RD: begin
                        ab           = r_bytes_left - 16'd1;
                        n_bytes_left = ab;
                        w0           = mk_word(ACT_READ_DATA, 8'h00, rx, 8'h00, 16'h0000);
                        if (ab != 16'd0) begin
                            cnt = 2'd2;
                            w1  = mk_send(DUMMY_BYTE);
                        end else begin
                            cnt     = 2'd3;
                            w1      = mk_plain(ACT_RAISE_SELECT);
                            w2      = mk_plain(ACT_DONE);
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_WRDI: begin
                        cnt     = 2'd2;
                        w0      = mk_plain(ACT_RAISE_SELECT);
                        w1      = mk_plain(ACT_DONE);
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        cnt = 2'd0;
                    end
                endcase
            end
            default: begin
                cnt = 2'd0;
            end
        endcase

        case (cnt)
            2'd1:    w0.last = 1'b1;
            2'd2:    w1.last = 1'b1;
            2'd3:    w2.last = 1'b1;
            default: w0.last = 1'b0;
        endcase

        o_batch.words = {w2, w1, w0};
        o_batch.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_op         <= OP_NONE;
            r_bytes_left <= '0;
            r_addr       <= '0;
            r_wptr       <= '0;
            r_id_first   <= '0;
            r_id_high    <= '0;
            r_rec_len    <= RecordLengthReset;
            r_fill_lim   <= PageFillLimitReset;
        end else begin
            if (i_go) begin
                r_phase      <= n_phase;
                r_op         <= n_op;
                r_bytes_left <= n_bytes_left;
                r_addr       <= n_addr;
                r_wptr       <= n_wptr;
                r_id_first   <= n_id_first;
                r_id_high    <= n_id_high;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RECORD_LENGTH:   r_rec_len  <= i_cfg_data;
                    CFG_PAGE_FILL_LIMIT: r_fill_lim <= i_cfg_data;
                    default:             r_rec_len  <= r_rec_len;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/snfcs_outq.sv =====
// Result buffer: holds the words of one decision and hands them out one per cycle while the receiver is ready.
`default_nettype none

module snfcs_outq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire snfcs_pkg::t_batch    i_batch,
    output logic                      o_free,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output snfcs_pkg::t_out_word      o_data
);
    import snfcs_pkg::*;

    t_out_word  r_buf [MaxWords];
    logic [1:0] r_cnt;
    logic [1:0] r_idx;
    logic       take;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_idx];
    assign take    = o_valid && i_ready;
    assign o_free  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.count;
            r_idx <= 2'd0;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < MaxWords; k++) begin
                r_buf[k] <= i_batch.words[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spi_nor_flash_command_sequencer_top.sv =====
// Top level of the SPI NOR flash command sequencer: input register, sequencer, result buffer.
//
//   channel  direction  handshake                       word
//   in       to block   i_in_valid / o_in_ready         i_in_data  (t_in_word)
//   out      from block o_out_valid / i_out_ready       o_out_data (t_out_word)
//   cfg      to block   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// An accepted word waits in the input register until the result buffer is free; it is then
// decided in a single pass through the sequencer logic and yields zero to three result words.
// Result words leave one per cycle while the output is ready; the result buffer takes a
// new decision in the same cycle that its last word is taken, or at once when it is empty.
// Reset is synchronous and active low; it clears the sequencer to idle and loads the
// register defaults (record length 50, page fill limit 250).
// A stalled output holds the buffer; one further input word waits in the input register.
`default_nettype none

module spi_nor_flash_command_sequencer_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire snfcs_pkg::t_in_word  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output snfcs_pkg::t_out_word      o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [8:0]           i_cfg_data
);
    import snfcs_pkg::*;

    logic     r_in_valid;
    t_in_word r_in;
    logic     q_free;
    logic     go;
    t_batch   batch;

    assign go          = r_in_valid && q_free;
    assign o_in_ready  = !r_in_valid || go;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    snfcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_word      (r_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_batch     (batch)
    );

    snfcs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (go),
        .i_batch (batch),
        .o_free  (q_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last |=> !o_out_valid || $past(go))
        else $error("result words left after the final word");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |=> o_out_valid)
        else $error("non-final word not followed by another");

    a_batch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && batch.count == 2'd3 |-> batch.words[2].last && !batch.words[0].last)
        else $error("final mark misplaced in a full batch");

endmodule

`default_nettype wire

// ===== sim/spi_nor_flash_command_sequencer_top_test.sv =====
// Self-checking testbench for the SPI NOR flash command sequencer top level.
`default_nettype none

module spi_nor_flash_command_sequencer_top_test;

    import snfcs_pkg::*;

    localparam logic [2:0] CmdUnused = 3'd7;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ID_CMD   = 5'd1,
        PH_ID_MFR   = 5'd2,
        PH_ID_DEV1  = 5'd3,
        PH_ID_DEV2  = 5'd4,
        PH_POLL_CMD = 5'd5,
        PH_POLL_ST  = 5'd6,
        PH_WREN     = 5'd7,
        PH_OPCODE   = 5'd8,
        PH_ADDR_HI  = 5'd9,
        PH_ADDR_MID = 5'd10,
        PH_ADDR_LO  = 5'd11,
        PH_WANT     = 5'd12,
        PH_DATA     = 5'd13,
        PH_READ     = 5'd14,
        PH_WRDI     = 5'd15
    } t_flash_phase;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_ERASE = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3
    } t_flash_op;

    typedef struct packed {
        logic [8:0]   record_length;
        logic [8:0]   fill_limit;
        t_flash_phase phase;
        t_flash_op    operation;
        logic [15:0]  bytes_left;
        logic [23:0]  flash_address;
        logic [23:0]  write_pointer;
        logic [7:0]   id_first;
        logic [7:0]   id_high;
        logic         select_low;
    } t_flash_state;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    t_in_word     in_data = '0;
    logic         in_ready;
    logic         out_valid;
    logic         out_ready = 1'b0;
    t_out_word    out_data;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    t_cfg_index   cfg_index = CFG_RECORD_LENGTH;
    logic [8:0]   cfg_data = '0;

    t_in_word     pending_words[$];
    t_out_word    expected_words[$];
    t_flash_state flash_model;
    t_flash_state host_plan;
    int unsigned  send_idle_pct = 22;
    int unsigned  recv_idle_pct = 58;
    int unsigned  fed_words;
    int unsigned  mismatches = 0;

    spi_nor_flash_command_sequencer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic t_flash_state reset_state();
        t_flash_state s;
        s = '0;
        s.record_length = RecordLengthReset;
        s.fill_limit    = PageFillLimitReset;
        s.phase         = PH_IDLE;
        s.operation     = OP_NONE;
        return s;
    endfunction

    function automatic void emit_word(inout t_batch b, input t_action act,
                                      input logic [7:0] tx, input logic [7:0] rd,
                                      input logic [7:0] mfr, input logic [15:0] dev);
        t_out_word w;
        w.action       = act;
        w.tx_byte      = tx;
        w.read_byte    = rd;
        w.manufacturer = mfr;
        w.device       = dev;
        w.last         = 1'b0;
        b.words[b.count] = w;
        b.count = b.count + 2'd1;
    endfunction

    function automatic void shift_out(inout t_flash_state s, inout t_batch b,
                                      input logic [7:0] tx, input t_flash_phase nxt);
        emit_word(b, ACT_SEND_BYTE, tx, 8'h00, 8'h00, 16'h0000);
        s.select_low = 1'b1;
        s.phase = nxt;
    endfunction

    function automatic void release_select(inout t_flash_state s, inout t_batch b);
        emit_word(b, ACT_RAISE_SELECT, 8'h00, 8'h00, 8'h00, 16'h0000);
        s.select_low = 1'b0;
    endfunction

    function automatic void finish_op(inout t_flash_state s, inout t_batch b);
        release_select(s, b);
        emit_word(b, ACT_DONE, 8'h00, 8'h00, 8'h00, 16'h0000);
        s.phase = PH_IDLE;
    endfunction

    function automatic void close_write(inout t_flash_state s, inout t_batch b);
        release_select(s, b);
        shift_out(s, b, OPC_WRDI, PH_WRDI);
    endfunction

    function automatic void after_transfer(inout t_flash_state s, inout t_batch b);
        case (s.operation)
            OP_ERASE: close_write(s, b);
            OP_WRITE: begin
                if (s.bytes_left != 0) begin
                    emit_word(b, ACT_WANT_DATA, 8'h00, 8'h00, 8'h00, 16'h0000);
                    s.phase = PH_WANT;
                end else begin
                    close_write(s, b);
                end
            end
            default: begin
                if (s.bytes_left != 0) shift_out(s, b, DUMMY_BYTE, PH_READ);
                else finish_op(s, b);
            end
        endcase
    endfunction

    function automatic void take_byte(inout t_flash_state s, inout t_batch b,
                                      input logic [7:0] rx);
        case (s.phase)
            PH_ID_CMD:  shift_out(s, b, OPC_READ_ID, PH_ID_MFR);
            PH_ID_MFR: begin
                s.id_first = rx;
                shift_out(s, b, DUMMY_BYTE, PH_ID_DEV1);
            end
            PH_ID_DEV1: begin
                s.id_high = rx;
                shift_out(s, b, DUMMY_BYTE, PH_ID_DEV2);
            end
            PH_ID_DEV2: begin
                release_select(s, b);
                emit_word(b, ACT_ID_RESULT, 8'h00, 8'h00, s.id_first, {s.id_high, rx});
                emit_word(b, ACT_DONE, 8'h00, 8'h00, 8'h00, 16'h0000);
                s.phase = PH_IDLE;
            end
            PH_POLL_CMD: shift_out(s, b, DUMMY_BYTE, PH_POLL_ST);
            PH_POLL_ST: begin
                if (rx[0]) begin
                    shift_out(s, b, DUMMY_BYTE, PH_POLL_ST);
                end else begin
                    release_select(s, b);
                    if (s.operation == OP_READ) shift_out(s, b, OPC_READ, PH_OPCODE);
                    else shift_out(s, b, OPC_WREN, PH_WREN);
                end
            end
            PH_WREN: begin
                release_select(s, b);
                shift_out(s, b, (s.operation == OP_ERASE) ? OPC_ERASE : OPC_PROGRAM, PH_OPCODE);
            end
            PH_OPCODE:   shift_out(s, b, s.flash_address[23:16], PH_ADDR_HI);
            PH_ADDR_HI:  shift_out(s, b, s.flash_address[15:8], PH_ADDR_MID);
            PH_ADDR_MID: shift_out(s, b, s.flash_address[7:0], PH_ADDR_LO);
            PH_ADDR_LO:  after_transfer(s, b);
            PH_DATA: begin
                s.bytes_left = s.bytes_left - 16'd1;
                after_transfer(s, b);
            end
            PH_READ: begin
                emit_word(b, ACT_READ_DATA, 8'h00, rx, 8'h00, 16'h0000);
                s.bytes_left = s.bytes_left - 16'd1;
                if (s.bytes_left != 0) shift_out(s, b, DUMMY_BYTE, PH_READ);
                else finish_op(s, b);
            end
            PH_WRDI: finish_op(s, b);
            default: ;
        endcase
    endfunction

    function automatic void start_polled(inout t_flash_state s, inout t_batch b,
                                         input t_flash_op op, input logic [23:0] addr,
                                         input logic [15:0] len);
        s.operation     = op;
        s.flash_address = addr;
        s.bytes_left    = len;
        shift_out(s, b, OPC_READ_SR, PH_POLL_CMD);
    endfunction

    function automatic t_batch sequencer_step(inout t_flash_state s, input t_in_word w);
        t_batch      b;
        logic [23:0] addr;
        logic [23:0] dest;
        b = '0;
        addr = {w.block, w.sector, w.page, w.offset};
        if (w.command <= CMD_APPEND) begin
            if (s.phase == PH_IDLE) begin
                case (w.command)
                    CMD_READ_ID:      shift_out(s, b, OPC_READ_ID, PH_ID_CMD);
                    CMD_ERASE_SECTOR: start_polled(s, b, OP_ERASE, {addr[23:12], 12'h000}, 16'd0);
                    CMD_PAGE_WRITE:   start_polled(s, b, OP_WRITE, addr, w.length);
                    CMD_READ:         start_polled(s, b, OP_READ, addr, w.length);
                    default: begin
                        if ({1'b0, s.write_pointer[7:0]} >= s.fill_limit)
                            dest = {s.write_pointer[23:8] + 16'd1, 8'h00};
                        else
                            dest = s.write_pointer;
                        s.write_pointer = dest + 24'(s.record_length);
                        start_polled(s, b, OP_WRITE, dest, 16'(s.record_length));
                    end
                endcase
            end
        end else if (w.command == CMD_WRITE_DATA) begin
            if (s.phase == PH_WANT) shift_out(s, b, w.byte_value, PH_DATA);
        end else if (w.command == CMD_SPI_RECEIVED) begin
            take_byte(s, b, w.byte_value);
        end
        if (b.count != 0) b.words[b.count - 2'd1].last = 1'b1;
        return b;
    endfunction

    function automatic t_in_word host_word(input t_flash_state s, input bit noisy);
        t_in_word w;
        w.command    = CMD_SPI_RECEIVED;
        w.block      = 8'($urandom);
        w.sector     = 4'($urandom);
        w.page       = 4'($urandom);
        w.offset     = 8'($urandom);
        w.length     = 16'($urandom);
        w.byte_value = 8'($urandom);
        if (noisy)
            w.command = 3'($urandom_range(CMD_READ_ID, CmdUnused));
        else if (s.phase == PH_IDLE)
            w.command = 3'($urandom_range(CMD_READ_ID, CMD_APPEND));
        else if (s.phase == PH_WANT)
            w.command = CMD_WRITE_DATA;
        else if (s.phase == PH_POLL_ST)
            w.byte_value[0] = ($urandom_range(99) < 35);
        if (s.phase == PH_IDLE)
            w.length = ($urandom_range(9) == 0) ? 16'($urandom_range(7, 40))
                                                : 16'($urandom_range(0, 6));
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic feed(input t_in_word w);
        t_batch b;
        b = sequencer_step(host_plan, w);
        pending_words.push_back(w);
        fed_words++;
    endtask

    task automatic complete();
        while (host_plan.phase != PH_IDLE) feed(host_word(host_plan, 1'b0));
    endtask

    task automatic request(input t_command cmd, input logic [7:0] blk, input logic [3:0] sec,
                           input logic [3:0] pg, input logic [7:0] off,
                           input logic [15:0] len);
        t_in_word w;
        w = host_word(host_plan, 1'b0);
        w.command = cmd;
        w.block   = blk;
        w.sector  = sec;
        w.page    = pg;
        w.offset  = off;
        w.length  = len;
        feed(w);
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_RECORD_LENGTH) begin
            flash_model.record_length = value;
            host_plan.record_length   = value;
        end else begin
            flash_model.fill_limit = value;
            host_plan.fill_limit   = value;
        end
        @(posedge clk);
    endtask

    task automatic run_random(input int unsigned sender_pct, input int unsigned receiver_pct,
                              input logic [8:0] rec_len, input logic [8:0] fill_limit);
        wait_idle();
        write_register(CFG_RECORD_LENGTH, rec_len);
        write_register(CFG_PAGE_FILL_LIMIT, fill_limit);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        fed_words = 0;
        while (fed_words < 60) feed(host_word(host_plan, $urandom_range(99) < 12));
        complete();
    endtask

    always @(posedge clk) begin : drive_words
        t_batch b;
        logic   next_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            next_valid = in_valid;
            if (in_valid && in_ready) begin
                b = sequencer_step(flash_model, in_data);
                for (int k = 0; k < b.count; k++) expected_words.push_back(b.words[k]);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_words.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                in_data <= pending_words.pop_front();
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk) begin : check_words
        t_out_word want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing expected, action", out_data.action, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (out_data.action !== want.action)
                        report_mismatch("action", out_data.action, want.action);
                    if (out_data.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", out_data.tx_byte, want.tx_byte);
                    if (out_data.read_byte !== want.read_byte)
                        report_mismatch("read_byte", out_data.read_byte, want.read_byte);
                    if (out_data.manufacturer !== want.manufacturer)
                        report_mismatch("manufacturer", out_data.manufacturer,
                                        want.manufacturer);
                    if (out_data.device !== want.device)
                        report_mismatch("device", out_data.device, want.device);
                    if (out_data.last !== want.last)
                        report_mismatch("last", out_data.last, want.last);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        t_in_word w;
        flash_model = reset_state();
        host_plan   = reset_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        request(CMD_READ_ID, 8'hFF, 4'hF, 4'hF, 8'hFF, 16'hFFFF);
        complete();
        request(CMD_ERASE_SECTOR, 8'hFF, 4'hF, 4'hF, 8'hFF, 16'd0);
        complete();
        request(CMD_PAGE_WRITE, 8'h00, 4'h0, 4'h0, 8'h00, 16'd0);
        complete();
        request(CMD_PAGE_WRITE, 8'h5A, 4'hF, 4'h0, 8'hFE, 16'd2);
        complete();
        request(CMD_READ, 8'h00, 4'h0, 4'h0, 8'h00, 16'd0);
        complete();
        request(CMD_READ, 8'hA5, 4'h3, 4'hC, 8'hFF, 16'd3);
        complete();
        w = host_word(host_plan, 1'b0);
        w.command = CMD_SPI_RECEIVED;
        feed(w);
        w.command = CMD_WRITE_DATA;
        feed(w);
        w.command = CmdUnused;
        feed(w);
        request(CMD_READ_ID, 8'h00, 4'h0, 4'h0, 8'h00, 16'd0);
        request(CMD_ERASE_SECTOR, 8'h12, 4'h3, 4'h4, 8'h56, 16'd0);
        w = host_word(host_plan, 1'b0);
        w.command = CMD_WRITE_DATA;
        feed(w);
        complete();
        request(CMD_APPEND, 8'h00, 4'h0, 4'h0, 8'h00, 16'd0);
        complete();
        wait_idle();
        write_register(CFG_RECORD_LENGTH, 9'd0);
        request(CMD_APPEND, 8'h00, 4'h0, 4'h0, 8'h00, 16'd0);
        complete();
        wait_idle();
        write_register(CFG_RECORD_LENGTH, 9'd3);
        write_register(CFG_PAGE_FILL_LIMIT, 9'd2);
        request(CMD_APPEND, 8'h00, 4'h0, 4'h0, 8'h00, 16'd0);
        complete();
        request(CMD_APPEND, 8'h00, 4'h0, 4'h0, 8'h00, 16'd0);
        complete();

        run_random(22, 58, 9'd1, 9'd1);
        run_random(58, 22, 9'd33, 9'd256);
        run_random(0, 0, 9'd7, 9'd200);
        request(CMD_READ, 8'hFF, 4'hF, 4'hF, 8'h00, 16'd2);
        complete();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== spi_nor_flash_command_sequencer_top.f =====
hw/rtl/snfcs_pkg.sv
hw/rtl/snfcs_core.sv
hw/rtl/snfcs_outq.sv
hw/rtl/spi_nor_flash_command_sequencer_top.sv
sim/spi_nor_flash_command_sequencer_top_test.sv
